@@ rtl/overwriting_record_ring_queue_core_macros.svh @@
// Assertion macros shared by the ring queue checker.
`ifndef OVERWRITING_RECORD_RING_QUEUE_CORE_MACROS_SVH
`define OVERWRITING_RECORD_RING_QUEUE_CORE_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ORRQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ORRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/orrq_pkg.sv @@
package orrq_pkg;

    localparam int CAPACITY = 16;
    localparam int CODE_LEN = 8;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int SEQ_W    = 32;
    localparam int CODE_W   = 56;
    localparam int IN_LEN_W = 8;
    localparam int LEN_W    = 3;
    localparam int DELTA_W  = 32;
    localparam int OCC_W    = 5;
    localparam int OP_W     = 2;

    localparam int CODE_CHARS = CODE_W / 8;
    localparam int LEN_LIMIT  = CODE_LEN - 1;

    localparam int S_DATA_W = 128;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 128;
    localparam int M_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_PEEK    = 2'd1,
        OP_POP     = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    // Sequence sits in the low bits so the record packs straight into tdata.
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [LEN_W-1:0]          len;
        logic [CODE_W-1:0]         code;
        logic [SEQ_W-1:0]          seq;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        op_t                       op;
        logic signed [DELTA_W-1:0] delta;
        logic [IN_LEN_W-1:0]       len;
        logic [CODE_W-1:0]         code;
        logic [SEQ_W-1:0]          seq;
    } in_item_t;

    typedef struct packed {
        logic             ok;
        logic             over;
        logic [OCC_W-1:0] occ;
        rec_t             rec;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic             ok;
        logic             over;
        logic             rd;
        logic [CNT_W-1:0] count;
    } pend_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

@@ rtl/orrq_ram.sv @@
module orrq_ram
    import orrq_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output rec_t     rd_data
);

    rec_t mem [CAPACITY];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        // Hold read data until the next read request.
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/orrq_code_trim.sv @@
module orrq_code_trim
    import orrq_pkg::*;
(
    input  logic [CODE_W-1:0]   code,
    input  logic [IN_LEN_W-1:0] code_length,
    output logic [CODE_W-1:0]   kept_code,
    output logic [LEN_W-1:0]    kept_len
);

    logic [LEN_W-1:0] limit;
    logic             alive;

    assign limit = (code_length < IN_LEN_W'(LEN_LIMIT)) ? code_length[LEN_W-1:0]
                                                          : LEN_W'(LEN_LIMIT);

    // Keep characters up to the limit, stop at the first zero character.
    always_comb begin
        kept_code = '0;
        kept_len  = '0;
        alive     = 1'b1;
        for (int i = 0; i < CODE_CHARS; i++) begin
            if (alive && (LEN_W'(i) < limit) && (code[8*i +: 8] != 8'h00)) begin
                kept_code[8*i +: 8] = code[8*i +: 8];
                kept_len            = LEN_W'(i + 1);
            end else begin
                alive = 1'b0;
            end
        end
    end

endmodule

@@ rtl/orrq_ctrl.sv @@
module orrq_ctrl
    import orrq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t item,
    input  logic     out_free,
    output logic     res_valid,
    output result_t  res,
    output ram_req_t ram_req,
    input  rec_t     ram_rd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    pend_t            pend_reg, pend_next;

    logic [CODE_W-1:0] kept_code;
    logic [LEN_W-1:0]  kept_len;
    logic              accept;

    orrq_code_trim u_trim (
        .code        (item.code),
        .code_length (item.len),
        .kept_code   (kept_code),
        .kept_len    (kept_len)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        ram_req    = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_RESP: begin
                in_ready = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        accept = in_valid && in_ready;

        if (accept) begin
            state_next = ST_RESP;
            pend_next  = '0;
            case (item.op) inside
                OP_ENQUEUE: begin
                    if ((item.seq != '0) && (kept_len != '0)) begin
                        pend_next.ok     = 1'b1;
                        ram_req.we       = 1'b1;
                        ram_req.wdata    = '{delta: item.delta, len: kept_len,
                                             code: kept_code, seq: item.seq};
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            // Full: replace the oldest record, head and tail move together.
                            ram_req.waddr  = head_reg;
                            head_next      = ring_next(head_reg);
                            tail_next      = ring_next(head_reg);
                            pend_next.over = 1'b1;
                        end else begin
                            ram_req.waddr = tail_reg;
                            tail_next     = ring_next(tail_reg);
                            count_next    = count_reg + 1'b1;
                        end
                    end
                end
                OP_PEEK, OP_POP: begin
                    if (count_reg != '0) begin
                        pend_next.ok  = 1'b1;
                        pend_next.rd  = 1'b1;
                        ram_req.re    = 1'b1;
                        ram_req.raddr = head_reg;
                        if (item.op == OP_POP) begin
                            count_next = count_reg - 1'b1;
                            if (count_reg == CNT_W'(1)) begin
                                head_next = '0;
                                tail_next = '0;
                            end else begin
                                head_next = ring_next(head_reg);
                            end
                        end
                    end
                end
                default: begin
                    head_next    = '0;
                    tail_next    = '0;
                    count_next   = '0;
                    pend_next.ok = 1'b1;
                end
            endcase
            pend_next.count = count_next;
        end
    end

    assign res_valid = (state_reg == ST_RESP);

    always_comb begin
        res      = '0;
        res.ok   = pend_reg.ok;
        res.over = pend_reg.over;
        res.occ  = OCC_W'(pend_reg.count);
        if (pend_reg.rd) begin
            res.rec = ram_rd;
        end
    end

endmodule

@@ rtl/overwriting_record_ring_queue_core.sv @@
// Response path: the request's RAM read and control result are registered at the accepting
// edge, then move into the output register that drives m_tvalid once it is free.
// Throughput: one request per cycle while m_tready stays high; the RAM read at the
// accepting edge and the output register at the next edge form the two stages.
// Reset: aresetn clears head, tail, count, control state and the output valid.
// The record RAM is not cleared; entries are read only after being written.
module overwriting_record_ring_queue_core
    import orrq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // sequence_req, code, code_length, delta
    input  logic [S_USER_W-1:0] s_tuser,  // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // out_sequence, out_code, out_code_length,
                                          // out_delta, occupancy
    output logic [M_USER_W-1:0] m_tuser   // ok, overwrote
);

    in_item_t item;
    result_t  res;
    result_t  out_reg;
    logic     res_valid;
    logic     out_valid_reg;
    logic     out_free;
    ram_req_t ram_req;
    rec_t     ram_rd;

    always_comb begin
        item.op = op_t'(s_tuser);
        {item.delta, item.len, item.code, item.seq} = s_tdata;
    end

    assign out_free = !out_valid_reg || m_tready;

    orrq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd)
    );

    orrq_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.occ, out_reg.rec};
    assign m_tuser  = {out_reg.over, out_reg.ok};

endmodule

@@ rtl/orrq_checker.sv @@
`include "overwriting_record_ring_queue_core_macros.svh"

module orrq_checker
    import orrq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    logic [OCC_W-1:0] occ;

    assign occ = m_tdata[M_DATA_W-1:REC_W];

    `ORRQ_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled result changed")
    `ORRQ_ASSERT(a_over_ok, aclk, aresetn,
        m_tvalid && m_tuser[1] |-> m_tuser[0],
        "overwrite flagged on a failed request")
    `ORRQ_ASSERT(a_fail_zero, aclk, aresetn,
        m_tvalid && !m_tuser[0] |-> m_tdata[REC_W-1:0] == '0,
        "failed request carries record data")
    `ORRQ_ASSERT(a_occ_cap, aclk, aresetn,
        m_tvalid |-> occ <= OCC_W'(CAPACITY),
        "occupancy above capacity")
    `ORRQ_ASSERT_ALWAYS(a_rst_idle, aclk,
        !aresetn |=> !m_tvalid,
        "result valid right after reset")

endmodule

bind overwriting_record_ring_queue_core orrq_checker u_orrq_checker (.*);
